// ===== src/assert_macros.svh =====
// assertion macros included by the allocator rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== src/fba_pkg.sv =====
// types and constants of the fixed block free list allocator
`default_nettype none
package fba_pkg;

   localparam int MAX_BLOCKS = 1024;
   localparam int INDEX_W    = $clog2(MAX_BLOCKS);
   localparam int LINK_W     = INDEX_W + 1;
   localparam int POOL_W     = 11;
   localparam int BYTES_W    = 13;
   localparam int OFFSET_W   = 22;
   localparam int PROD_W     = INDEX_W + BYTES_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);
   localparam logic [LINK_W-1:0] LINK_ONE  = LINK_W'(1);
   localparam logic [POOL_W-1:0] POOL_MAX  = POOL_W'(MAX_BLOCKS);

   localparam logic [POOL_W-1:0]  POOL_BLOCKS_RESET = POOL_W'(1024);
   localparam logic [BYTES_W-1:0] BLOCK_BYTES_RESET = BYTES_W'(64);

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BLOCKS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES = CSR_IDX_W'(1);

   typedef struct packed {
      logic               kind;
      logic [INDEX_W-1:0] block_index;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [INDEX_W-1:0]  granted_index;
      logic [OFFSET_W-1:0] byte_offset;
   } rsp_type;

   typedef struct packed {
      logic               wr_en;
      logic [INDEX_W-1:0] wr_addr;
      logic [LINK_W-1:0]  wr_data;
      logic               rd_en;
      logic [INDEX_W-1:0] rd_addr;
   } fba_mem_req_type;

   typedef enum logic {
      FBA_IDLE,
      FBA_WAIT
   } fba_state_type;

endpackage
`default_nettype wire

// ===== src/fba_link_mem.sv =====
// link memory of the free list, one write and one registered read port
`default_nettype none
module fba_link_mem (
   input  wire logic                         clock,
   input  wire fba_pkg::fba_mem_req_type     mem_req,
   output logic [fba_pkg::LINK_W-1:0]        rd_data
);

   logic [fba_pkg::LINK_W-1:0] link_ram [fba_pkg::MAX_BLOCKS];
   logic [fba_pkg::LINK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         link_ram[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= link_ram[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/fixed_block_free_list_allocator.sv =====
// fixed block pool allocator: lifo free list in memory plus a never-used watermark
// a free, or an allocate served from the watermark, gives its result in the cycle
// after the transaction; an allocate popped from the free list passes through the wait
// state and then the result register; throughput: one transaction a cycle, but a list
// pop holds busy through the wait state while the link memory read returns the next head
// reset (synchronous) empties the list, zeroes the watermark and restores the registers;
// the link memory is not cleared and the result strobe cannot be stalled
`default_nettype none
`include "assert_macros.svh"
module fixed_block_free_list_allocator (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire fba_pkg::req_type                 req_payload,
   output logic                                  rsp_valid,
   output fba_pkg::rsp_type                      rsp_payload,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [fba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [fba_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   fba_pkg::fba_state_type state_ff, state_in;

   logic [fba_pkg::POOL_W-1:0]  pool_blocks_ff;
   logic [fba_pkg::BYTES_W-1:0] block_bytes_ff;
   logic [fba_pkg::LINK_W-1:0]  head_ff, head_in;
   logic [fba_pkg::LINK_W-1:0]  fresh_ff, fresh_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   fba_pkg::rsp_type            rsp_payload_ff, rsp_payload_in;

   fba_pkg::fba_mem_req_type    mem_req;
   logic [fba_pkg::LINK_W-1:0]  link_rd_data;

   logic                        accept;
   logic                        head_valid;
   logic [fba_pkg::POOL_W-1:0]  pool_size;
   logic [1:0]                  status;
   logic [fba_pkg::INDEX_W-1:0] grant;
   logic [fba_pkg::PROD_W-1:0]  product;

   assign busy       = reset || (state_ff == fba_pkg::FBA_WAIT);
   assign accept     = start && !busy;
   assign csr_ready  = 1'b1;
   assign head_valid = !head_ff[fba_pkg::LINK_W-1];
   assign pool_size  = (pool_blocks_ff > fba_pkg::POOL_MAX) ? fba_pkg::POOL_MAX
                                                            : pool_blocks_ff;

   fba_link_mem u_link_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (link_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fba_pkg::FBA_IDLE: begin
            if (accept && req_payload.kind == fba_pkg::KIND_ALLOC && head_valid) begin
               state_in = fba_pkg::FBA_WAIT;
            end
         end
         fba_pkg::FBA_WAIT: begin
            state_in = fba_pkg::FBA_IDLE;
         end
         default: begin
            state_in = fba_pkg::FBA_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      mem_req      = '0;
      head_in      = head_ff;
      fresh_in     = fresh_ff;
      rsp_valid_in = 1'b0;
      status       = fba_pkg::STATUS_OK;
      grant        = '0;
      unique case (state_ff)
         fba_pkg::FBA_IDLE: begin
            if (accept) begin
               if (req_payload.kind == fba_pkg::KIND_ALLOC) begin
                  if (head_valid) begin
                     // pop: fetch the link of the head, the result is given from the wait state
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = head_ff[fba_pkg::INDEX_W-1:0];
                  end else if (fresh_ff < pool_size) begin
                     rsp_valid_in = 1'b1;
                     grant        = fresh_ff[fba_pkg::INDEX_W-1:0];
                     fresh_in     = fresh_ff + fba_pkg::LINK_ONE;
                  end else begin
                     rsp_valid_in = 1'b1;
                     status       = fba_pkg::STATUS_EMPTY;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
                  if ({1'b0, req_payload.block_index} < pool_size) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = req_payload.block_index;
                     mem_req.wr_data = head_ff;
                     head_in         = {1'b0, req_payload.block_index};
                  end else begin
                     status = fba_pkg::STATUS_RANGE;
                  end
               end
            end
         end
         fba_pkg::FBA_WAIT: begin
            rsp_valid_in = 1'b1;
            grant        = head_ff[fba_pkg::INDEX_W-1:0];
            head_in      = link_rd_data;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   assign product = {{fba_pkg::BYTES_W{1'b0}}, grant} *
                    {{fba_pkg::INDEX_W{1'b0}}, block_bytes_ff};

   always_comb begin
      rsp_payload_in.status        = status;
      rsp_payload_in.granted_index = grant;
      rsp_payload_in.byte_offset   = product[fba_pkg::OFFSET_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= fba_pkg::FBA_IDLE;
         head_ff        <= fba_pkg::NULL_LINK;
         fresh_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         pool_blocks_ff <= fba_pkg::POOL_BLOCKS_RESET;
         block_bytes_ff <= fba_pkg::BLOCK_BYTES_RESET;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               fba_pkg::CSR_POOL_BLOCKS: pool_blocks_ff <= csr_wdata[fba_pkg::POOL_W-1:0];
               fba_pkg::CSR_BLOCK_BYTES: block_bytes_ff <= csr_wdata[fba_pkg::BYTES_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `ASSERT_CLK(a_pop_waits, clock, reset, (accept && req_payload.kind == fba_pkg::KIND_ALLOC && head_valid) |=> (state_ff == fba_pkg::FBA_WAIT))
   `ASSERT_CLK(a_wait_one_cycle, clock, reset, (state_ff == fba_pkg::FBA_WAIT) |=> (state_ff == fba_pkg::FBA_IDLE) && rsp_valid)
   `ASSERT_CLK(a_rsp_has_cause, clock, reset, rsp_valid |-> ($past(accept) || $past(state_ff == fba_pkg::FBA_WAIT)))
   `ASSERT_CLK(a_no_read_write_mix, clock, reset, !(mem_req.rd_en && mem_req.wr_en))
   `ASSERT_CLK(a_wait_head_valid, clock, reset, (state_ff == fba_pkg::FBA_WAIT) |-> head_valid)

endmodule
`default_nettype wire

// ===== tb/tb_fixed_block_free_list_allocator.sv =====
// testbench of the fixed block free list allocator: directed and random transactions
module tb_fixed_block_free_list_allocator;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 100;

   // tracks the pool the way the block should and holds the results still due
   class pool_mirror;
      logic [fba_pkg::LINK_W-1:0]  next_link [fba_pkg::MAX_BLOCKS];
      logic [fba_pkg::LINK_W-1:0]  list_head;
      logic [fba_pkg::LINK_W-1:0]  fresh_next;
      logic [fba_pkg::POOL_W-1:0]  pool_reg;
      logic [fba_pkg::BYTES_W-1:0] bytes_reg;
      fba_pkg::rsp_type            due_q [$];
      int fails;
      int checked;
      int oks;
      int empties;
      int out_of_range;

      function new();
         list_head  = fba_pkg::NULL_LINK;
         fresh_next = '0;
         pool_reg   = fba_pkg::POOL_BLOCKS_RESET;
         bytes_reg  = fba_pkg::BLOCK_BYTES_RESET;
      endfunction

      function logic [fba_pkg::LINK_W-1:0] pool_limit();
         return (pool_reg > fba_pkg::POOL_MAX) ? fba_pkg::POOL_MAX : pool_reg;
      endfunction

      function void write_reg(logic [fba_pkg::CSR_IDX_W-1:0] idx,
                              logic [fba_pkg::CSR_DATA_W-1:0] data);
         if (idx == fba_pkg::CSR_POOL_BLOCKS) begin
            pool_reg = data[fba_pkg::POOL_W-1:0];
         end else if (idx == fba_pkg::CSR_BLOCK_BYTES) begin
            bytes_reg = data[fba_pkg::BYTES_W-1:0];
         end
      endfunction

      function fba_pkg::rsp_type note_request(fba_pkg::req_type r);
         fba_pkg::rsp_type            due;
         logic [fba_pkg::LINK_W-1:0]  lim;
         logic [fba_pkg::PROD_W-1:0]  prod;
         due = '0;
         lim = pool_limit();
         if (r.kind == fba_pkg::KIND_ALLOC) begin
            if (list_head < fba_pkg::NULL_LINK) begin
               due.granted_index = list_head[fba_pkg::INDEX_W-1:0];
               list_head = next_link[list_head[fba_pkg::INDEX_W-1:0]];
            end else if (fresh_next < lim) begin
               due.granted_index = fresh_next[fba_pkg::INDEX_W-1:0];
               fresh_next = fresh_next + fba_pkg::LINK_ONE;
            end else begin
               due.status = fba_pkg::STATUS_EMPTY;
            end
         end else if ({1'b0, r.block_index} < lim) begin
            next_link[r.block_index] = list_head;
            list_head = {1'b0, r.block_index};
         end else begin
            due.status = fba_pkg::STATUS_RANGE;
         end
         prod = due.granted_index * bytes_reg;
         due.byte_offset = prod[fba_pkg::OFFSET_W-1:0];
         due_q.push_back(due);
         return due;
      endfunction

      task report(string what, int got, int want);
         fails++;
         if (fails <= 40) begin
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
         end
      endtask

      task check_result(fba_pkg::rsp_type got);
         fba_pkg::rsp_type want;
         if (due_q.size() == 0) begin
            report("unexpected result", 1, 0);
         end else begin
            want = due_q.pop_front();
            checked++;
            if (want.status == fba_pkg::STATUS_OK && got.status == fba_pkg::STATUS_OK) oks++;
            if (want.status == fba_pkg::STATUS_EMPTY) empties++;
            if (want.status == fba_pkg::STATUS_RANGE) out_of_range++;
            if (got.status !== want.status) report("status", got.status, want.status);
            if (got.granted_index !== want.granted_index)
               report("granted_index", got.granted_index, want.granted_index);
            if (got.byte_offset !== want.byte_offset)
               report("byte_offset", got.byte_offset, want.byte_offset);
         end
      endtask
   endclass

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   fba_pkg::req_type               req_payload = '0;
   logic                           rsp_valid;
   fba_pkg::rsp_type               rsp_payload;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [fba_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [fba_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   pool_mirror  sb = new();
   int          cycles;
   int          settings;
   int          idle_pct;
   logic [fba_pkg::INDEX_W-1:0] held [$];

   fixed_block_free_list_allocator u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_fixed_block_free_list_allocator: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_payload);
   end

   // start stays high when the next transaction follows at once
   task automatic send_req(input logic kind, input logic [fba_pkg::INDEX_W-1:0] idx,
                           input int gap);
      fba_pkg::req_type r;
      fba_pkg::rsp_type due;
      r.kind = kind;
      r.block_index = idx;
      start <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      due = sb.note_request(r);
      if (kind == fba_pkg::KIND_ALLOC && due.status == fba_pkg::STATUS_OK)
         held.push_back(due.granted_index);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [fba_pkg::CSR_IDX_W-1:0] idx,
                            input logic [fba_pkg::CSR_DATA_W-1:0] data);
      start <= 1'b0;
      while (sb.due_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      csr_valid <= 1'b0;
      settings++;
   endtask

   task automatic send_random();
      int pick;
      int k;
      logic [fba_pkg::LINK_W-1:0] lim;
      logic [fba_pkg::INDEX_W-1:0] idx;
      int gap;
      gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 3) : 0;
      pick = $urandom_range(0, 99);
      lim = sb.pool_limit();
      if (pick < ((held.size() > 40) ? 30 : 55)) begin
         send_req(fba_pkg::KIND_ALLOC, fba_pkg::INDEX_W'($urandom), gap);
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 75 && held.size() > 0) begin
            k = $urandom_range(0, held.size() - 1);
            idx = held[k];
            held.delete(k);
         end else if (pick < 90 && lim > 0) begin
            // in range, may be a double free or a never-used block
            idx = fba_pkg::INDEX_W'($urandom_range(0, lim - 1));
         end else begin
            idx = fba_pkg::INDEX_W'($urandom);
         end
         send_req(fba_pkg::KIND_FREE, idx, gap);
      end
   endtask

   initial begin
      int pool_set [RANDOM_PHASES];
      int bytes_set [RANDOM_PHASES];
      int idle_set [4];
      pool_set  = '{1024, 16, 1, 2047, 300, 5, 1024, 64};
      bytes_set = '{8, 4096, 8191, 0, 1234, 3, 64, 4095};
      // the receiver cannot stall, so the phases with a zero idle share run without sender gaps
      idle_set  = '{0, 50, 0, 17};
      settings = 0;
      idle_pct = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: watermark, list reuse, never-used free
      send_req(fba_pkg::KIND_ALLOC, 10'd0, 0);
      send_req(fba_pkg::KIND_ALLOC, 10'd1023, 0);
      send_req(fba_pkg::KIND_FREE, 10'd1, 0);
      send_req(fba_pkg::KIND_FREE, 10'd0, 0);
      send_req(fba_pkg::KIND_ALLOC, 10'd0, 0);
      send_req(fba_pkg::KIND_ALLOC, 10'd0, 1);
      send_req(fba_pkg::KIND_FREE, 10'd1023, 0);
      send_req(fba_pkg::KIND_ALLOC, 10'd0, 0);
      // pool shrunk to the watermark, out-of-range free, double free
      write_reg(fba_pkg::CSR_POOL_BLOCKS, 13'd2);
      write_reg(fba_pkg::CSR_BLOCK_BYTES, 13'd4096);
      send_req(fba_pkg::KIND_ALLOC, 10'd0, 0);
      send_req(fba_pkg::KIND_FREE, 10'd2, 0);
      send_req(fba_pkg::KIND_FREE, 10'd1, 0);
      send_req(fba_pkg::KIND_FREE, 10'd1, 0);
      send_req(fba_pkg::KIND_ALLOC, 10'd0, 0);
      send_req(fba_pkg::KIND_ALLOC, 10'd0, 0);
      send_req(fba_pkg::KIND_ALLOC, 10'd0, 0);
      // empty pool
      write_reg(fba_pkg::CSR_POOL_BLOCKS, 13'd0);
      send_req(fba_pkg::KIND_ALLOC, 10'd0, 0);
      send_req(fba_pkg::KIND_FREE, 10'd0, 0);
      // pool size above the maximum saturates, offset truncates
      write_reg(fba_pkg::CSR_POOL_BLOCKS, 13'h1FFF);
      write_reg(fba_pkg::CSR_BLOCK_BYTES, 13'h1FFF);
      send_req(fba_pkg::KIND_ALLOC, 10'd0, 0);
      send_req(fba_pkg::KIND_FREE, 10'd1023, 0);
      send_req(fba_pkg::KIND_ALLOC, 10'd0, 0);
      // block sizes of zero and below eight, writes to unused indexes
      write_reg(fba_pkg::CSR_BLOCK_BYTES, 13'd0);
      send_req(fba_pkg::KIND_ALLOC, 10'd0, 0);
      write_reg(fba_pkg::CSR_BLOCK_BYTES, 13'd5);
      send_req(fba_pkg::KIND_ALLOC, 10'd0, 0);
      write_reg(fba_pkg::CSR_BLOCK_BYTES + fba_pkg::CSR_IDX_W'(1), 13'h1FFF);
      write_reg('1, 13'd0);
      send_req(fba_pkg::KIND_ALLOC, 10'd0, 0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_reg(fba_pkg::CSR_POOL_BLOCKS, fba_pkg::CSR_DATA_W'(pool_set[p]));
         write_reg(fba_pkg::CSR_BLOCK_BYTES, fba_pkg::CSR_DATA_W'(bytes_set[p]));
         idle_pct = idle_set[p % 4];
         for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random();
      end

      start <= 1'b0;
      while (sb.due_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      $display("checked %0d transactions over %0d register writes", sb.checked, settings);
      $display("ok results %0d, pool empty %0d, free out of range %0d",
               sb.oks, sb.empties, sb.out_of_range);
      if (sb.fails == 0) begin
         $display("tb_fixed_block_free_list_allocator: PASS");
      end else begin
         $display("tb_fixed_block_free_list_allocator: FAIL");
      end
      $finish;
   end

endmodule
